// File: hdl/rarst_pkg.sv
// Shared types, widths and command codes of the range-add range-sum tree.
package rarst_pkg;

   // Field widths of the command and result beats
   localparam int IDX_W   = 11;
   localparam int DELTA_W = 32;
   localparam int SUM_W   = 64;

   // Walk position width: one bit above the index so that right + 1 and
   // an upward step past the last position both fit
   localparam int POS_W   = IDX_W + 1;

   // Largest value the index fields can carry
   localparam int IDX_MAX = (1 << IDX_W) - 1;

   // Default tree depth and cap on the size register at reset
   localparam int MAX_POS_DEF  = 1024;
   localparam int SIZE_RST_CAP = 1024;

   // Command codes
   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_QRY = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [IDX_W-1:0]   left_index;
      logic [IDX_W-1:0]   right_index;
      logic [DELTA_W-1:0] delta;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] range_sum;
      logic             range_error;
   } rsp_type;

endpackage

// File: hdl/rarst_chan_if.sv
// Valid/ready channel interfaces for command and result beats.
interface rarst_req_if;
   logic                                valid;
   logic                                ready;
   logic                                cmd;
   logic [rarst_pkg::IDX_W-1:0]         left_index;
   logic [rarst_pkg::IDX_W-1:0]         right_index;
   logic signed [rarst_pkg::DELTA_W-1:0] delta;

   modport source (output valid, cmd, left_index, right_index, delta, input ready);
   modport sink   (input valid, cmd, left_index, right_index, delta, output ready);
endinterface

interface rarst_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rarst_pkg::SUM_W-1:0] range_sum;
   logic                              range_error;

   modport source (output valid, range_sum, range_error, input ready);
   modport sink   (input valid, range_sum, range_error, output ready);
endinterface

// File: hdl/rarst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rarst_ram #(
   parameter int WIDTH = rarst_pkg::SUM_W,
   parameter int DEPTH = rarst_pkg::MAX_POS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rarst_engine.sv
// Tree sequencer: clearing pass, range-add and range-sum walks over two RAMs.
module rarst_engine #(
   parameter int MAX_POSITIONS = rarst_pkg::MAX_POS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rarst_pkg::IDX_W-1:0] size_in_use,
   input  logic                        start,
   input  rarst_pkg::req_type          cmd,
   output logic                        idle,
   input  logic                        res_ready,
   output logic                        res_valid,
   output rarst_pkg::rsp_type          res
);

   localparam int ADDR_W = $clog2(MAX_POSITIONS);
   localparam int POS_W  = rarst_pkg::POS_W;
   localparam int SUM_W  = rarst_pkg::SUM_W;
   localparam int DW     = rarst_pkg::DELTA_W;
   localparam int PL_W   = DW + rarst_pkg::IDX_W + 1;
   localparam int PR_W   = DW + POS_W + 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_POSITIONS - 1);

   // Sequencer states
   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_ADD_MUL  = 3'd2;
   localparam logic [2:0] ST_ADD_WALK = 3'd3;
   localparam logic [2:0] ST_QRY_WALK = 3'd4;
   localparam logic [2:0] ST_QRY_MUL  = 3'd5;
   localparam logic [2:0] ST_QRY_SUB  = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                pend_ff, pend_in;
   logic                second_ff, second_in;
   rarst_pkg::req_type  cmd_ff, cmd_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    wpos_ff, wpos_in;
   logic [SUM_W-1:0]    amt1_ff, amt1_in;
   logic [SUM_W-1:0]    amt2_ff, amt2_in;
   logic [SUM_W-1:0]    wr_ff, wr_in;
   logic [SUM_W-1:0]    acc1_ff, acc1_in;
   logic [SUM_W-1:0]    acc2_ff, acc2_in;
   logic [SUM_W-1:0]    prod_ff, prod_in;
   logic [SUM_W-1:0]    pre_ff, pre_in;
   rarst_pkg::rsp_type  res_ff, res_in;

   logic                mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]   mem_wr_addr, mem_rd_addr;
   logic [SUM_W-1:0]    wdata1, wdata2, rd1, rd2;

   logic [POS_W-1:0]    pos_low, size_pos, left_pos, right1, mul_x;
   logic                up_live, down_live, range_bad;
   logic [SUM_W-1:0]    d_ext, pl_ext, pr_ext, part;
   logic signed [PL_W-1:0] prod_l;
   logic signed [PR_W-1:0] prod_r;
   logic [SUM_W-1:0]    qprod;

   // Tree stores: delta tree and weighted tree share addresses
   rarst_ram #(.WIDTH(SUM_W), .DEPTH(MAX_POSITIONS)) u_delta_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (wdata1),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd1)
   );

   rarst_ram #(.WIDTH(SUM_W), .DEPTH(MAX_POSITIONS)) u_weight_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (wdata2),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd2)
   );

   // Position arithmetic for the walks
   assign pos_low   = pos_ff & (~pos_ff + POS_W'(1));
   assign size_pos  = POS_W'(size_in_use);
   assign up_live   = (pos_ff != '0) && (pos_ff <= size_pos);
   assign down_live = (pos_ff != '0);
   assign left_pos  = POS_W'(cmd_ff.left_index);
   assign right1    = POS_W'(cmd_ff.right_index) + POS_W'(1);

   assign range_bad = (cmd.left_index == '0) || (cmd.left_index > cmd.right_index) ||
                      (cmd.right_index > size_in_use);

   // Range-add weights: delta times left and delta times right + 1
   assign d_ext  = {{(SUM_W-DW){cmd_ff.delta[DW-1]}}, cmd_ff.delta};
   assign prod_l = $signed({{(PL_W-DW){cmd_ff.delta[DW-1]}}, cmd_ff.delta}) *
                   $signed({{(PL_W-rarst_pkg::IDX_W){1'b0}}, cmd_ff.left_index});
   assign prod_r = $signed({{(PR_W-DW){cmd_ff.delta[DW-1]}}, cmd_ff.delta}) *
                   $signed({{(PR_W-POS_W){1'b0}}, right1});
   assign pl_ext = {{(SUM_W-PL_W){prod_l[PL_W-1]}}, prod_l};
   assign pr_ext = {{(SUM_W-PR_W){prod_r[PR_W-1]}}, prod_r};

   // Prefix scale: x + 1 is right + 1 for the first prefix, left for the second
   assign mul_x = second_ff ? left_pos : right1;
   assign qprod = acc1_ff * {{(SUM_W-POS_W){1'b0}}, mul_x};
   assign part  = prod_ff - acc2_ff;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      pend_in     = pend_ff;
      second_in   = second_ff;
      cmd_in      = cmd_ff;
      pos_in      = pos_ff;
      wpos_in     = wpos_ff;
      amt1_in     = amt1_ff;
      amt2_in     = amt2_ff;
      wr_in       = wr_ff;
      acc1_in     = acc1_ff;
      acc2_in     = acc2_ff;
      prod_in     = prod_ff;
      pre_in      = pre_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_wr_addr = ADDR_W'(wpos_ff - POS_W'(1));
      mem_rd_addr = ADDR_W'(pos_ff - POS_W'(1));
      wdata1      = rd1 + amt1_ff;
      wdata2      = rd2 + amt2_ff;
      idle        = 1'b0;
      res_valid   = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one entry of each tree per cycle
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            wdata1      = '0;
            wdata2      = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               cmd_in    = cmd;
               second_in = 1'b0;
               pend_in   = 1'b0;
               acc1_in   = '0;
               acc2_in   = '0;
               pos_in    = POS_W'(cmd.right_index);
               if (range_bad) begin
                  res_in.range_sum   = '0;
                  res_in.range_error = 1'b1;
                  state_in           = ST_DONE;
               end else if (cmd.cmd == rarst_pkg::CMD_ADD) begin
                  state_in = ST_ADD_MUL;
               end else begin
                  state_in = ST_QRY_WALK;
               end
            end
         end
         ST_ADD_MUL: begin
            // Latch the products, start the walk up from left
            amt1_in  = d_ext;
            amt2_in  = pl_ext;
            wr_in    = pr_ext;
            pos_in   = left_pos;
            state_in = ST_ADD_WALK;
         end
         ST_ADD_WALK: begin
            // Read the next entry while writing back the one read last cycle
            pend_in = up_live;
            if (up_live) begin
               mem_rd_en = 1'b1;
               wpos_in   = pos_ff;
               pos_in    = pos_ff + pos_low;
            end
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (!up_live && !pend_ff) begin
               if (!second_ff) begin
                  second_in = 1'b1;
                  pos_in    = right1;
                  amt1_in   = '0 - amt1_ff;
                  amt2_in   = '0 - wr_ff;
               end else begin
                  res_in.range_sum   = '0;
                  res_in.range_error = 1'b0;
                  state_in           = ST_DONE;
               end
            end
         end
         ST_QRY_WALK: begin
            // Walk down, accumulating both trees
            pend_in = down_live;
            if (down_live) begin
               mem_rd_en = 1'b1;
               pos_in    = pos_ff - pos_low;
            end
            if (pend_ff) begin
               acc1_in = acc1_ff + rd1;
               acc2_in = acc2_ff + rd2;
            end
            if (!down_live && !pend_ff) begin
               state_in = ST_QRY_MUL;
            end
         end
         ST_QRY_MUL: begin
            prod_in  = qprod;
            state_in = ST_QRY_SUB;
         end
         ST_QRY_SUB: begin
            if (!second_ff) begin
               // Hold prefix(right), then walk from left - 1
               pre_in    = part;
               second_in = 1'b1;
               pos_in    = left_pos - POS_W'(1);
               acc1_in   = '0;
               acc2_in   = '0;
               state_in  = ST_QRY_WALK;
            end else begin
               res_in.range_sum   = pre_ff - part;
               res_in.range_error = 1'b0;
               state_in           = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         pend_ff     <= 1'b0;
         second_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         pend_ff     <= pend_in;
         second_ff   <= second_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      pos_ff  <= pos_in;
      wpos_ff <= wpos_in;
      amt1_ff <= amt1_in;
      amt2_ff <= amt2_in;
      wr_ff   <= wr_in;
      acc1_ff <= acc1_in;
      acc2_ff <= acc2_in;
      prod_ff <= prod_in;
      pre_ff  <= pre_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;

endmodule

// File: hdl/range_add_range_sum_tree_top.sv
// Top level of the range-add range-sum tree: size register, channels, sequencer.
//
//   channel  | dir | beat
//   ---------+-----+--------------------------------------------------
//   req_bus  | in  | cmd, left_index, right_index, delta
//   rsp_bus  | out | range_sum, range_error
//   csr_*    | in  | size_in_use write (wr_en, wr_data), no read-back
//
// One command at a time. A range add makes two upward walks and a range sum two
// downward walks over the trees, each walk at most log2(size) + 1 steps long.
// A rejected command skips the walks and goes straight to its result. After
// reset a clearing pass over all MAX_POSITIONS entries zeroes both trees;
// req_bus.ready stays low until then.
// One finished result waits in the output register while the next command runs.
module range_add_range_sum_tree_top #(
   parameter int MAX_POSITIONS = rarst_pkg::MAX_POS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   rarst_req_if.sink                   req_bus,
   rarst_rsp_if.source                 rsp_bus,
   input  logic                        csr_wr_en,
   input  logic [rarst_pkg::IDX_W-1:0] csr_wr_data
);

   localparam int IDX_W   = rarst_pkg::IDX_W;
   localparam int CAP_INT = (MAX_POSITIONS < rarst_pkg::IDX_MAX) ?
                            MAX_POSITIONS : rarst_pkg::IDX_MAX;
   localparam int RST_INT = (MAX_POSITIONS < rarst_pkg::SIZE_RST_CAP) ?
                            MAX_POSITIONS : rarst_pkg::SIZE_RST_CAP;
   localparam logic [IDX_W-1:0] SIZE_CAP = IDX_W'(CAP_INT);
   localparam logic [IDX_W-1:0] SIZE_RST = IDX_W'(RST_INT);

   logic [IDX_W-1:0]   size_ff, size_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rarst_pkg::rsp_type rsp_data_ff;
   rarst_pkg::req_type req_beat;
   rarst_pkg::rsp_type eng_res;
   logic               eng_idle, eng_res_valid, eng_res_ready, start, load;

   // Clamp the size register into 1..min(MAX_POSITIONS, IDX_MAX) on write
   always_comb begin
      size_in = size_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            size_in = IDX_W'(1);
         end else if (csr_wr_data > SIZE_CAP) begin
            size_in = SIZE_CAP;
         end else begin
            size_in = csr_wr_data;
         end
      end
   end

   // Take a command beat whenever the sequencer is free
   assign start                = req_bus.valid && eng_idle;
   assign req_bus.ready        = eng_idle;
   assign req_beat.cmd         = req_bus.cmd;
   assign req_beat.left_index  = req_bus.left_index;
   assign req_beat.right_index = req_bus.right_index;
   assign req_beat.delta       = req_bus.delta;

   rarst_engine #(.MAX_POSITIONS(MAX_POSITIONS)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .size_in_use (size_ff),
      .start       (start),
      .cmd         (req_beat),
      .idle        (eng_idle),
      .res_ready   (eng_res_ready),
      .res_valid   (eng_res_valid),
      .res         (eng_res)
   );

   // Output register: load when empty or being drained
   assign eng_res_ready = !rsp_valid_ff || rsp_bus.ready;
   assign load          = eng_res_valid && eng_res_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= eng_res;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.range_sum   = rsp_data_ff.range_sum;
   assign rsp_bus.range_error = rsp_data_ff.range_error;

   // Size register stays within the tree
   a_size_range: assert property (@(posedge clock) disable iff (reset)
      (size_ff != '0) && (int'(size_ff) <= MAX_POSITIONS))
      else $error("size register outside 1..MAX_POSITIONS");

   // An accepted command takes the sequencer out of idle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> !eng_idle)
      else $error("sequencer idle after accepting a command");

   // A finished result is never offered while idle
   a_res_not_idle: assert property (@(posedge clock) disable iff (reset)
      eng_res_valid |-> !eng_idle)
      else $error("result offered by an idle sequencer");

   // Rejected commands carry a zero sum
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.range_error) |-> (rsp_data_ff.range_sum == '0))
      else $error("rejected command with non-zero sum");

endmodule
